// File: rtl/core/c2ca_pkg.sv
package c2ca_pkg;

	localparam int COORD_BITS_DEF      = 16;
	localparam int RATIO_FRAC_BITS_DEF = 16;

	localparam int ANGLE_BITS = 16;
	localparam int ANGLE_MAX  = 36000;

	// coefficients in centidegrees, Q20
	localparam int CFRAC    = 20;
	localparam int COEF_A_W = 32;
	localparam int P_W      = 34;
	localparam int Q_W      = P_W + 3;
	localparam int TOT_W    = 40;
	localparam int RND_W    = TOT_W - CFRAC;

	localparam logic signed [COEF_A_W-1:0] COEF_A = -32'sd1641298640;
	localparam logic signed [P_W-1:0]      COEF_B = 34'sd6360939112;
	localparam logic signed [Q_W-1:0]      COEF_C = -37'sd524267;

	typedef enum logic [2:0] {
		BASE_0,
		BASE_90,
		BASE_180,
		BASE_270,
		BASE_360
	} base_t;

	typedef struct packed {
		base_t base;
		logic  add;
		logic  zero;
	} octant_t;

	// octant base in Q20 centidegrees, with the half-LSB rounding term folded in
	function automatic logic signed [TOT_W-1:0] base_bias(input base_t b);
		logic signed [TOT_W-1:0] v;
		unique case (b)
			BASE_0:   v = 40'sd524288;
			BASE_90:  v = 40'sd9437708288;
			BASE_180: v = 40'sd18874892288;
			BASE_270: v = 40'sd28312076288;
			BASE_360: v = 40'sd37749260288;
			default:  v = 40'sd524288;
		endcase
		return v;
	endfunction

endpackage

// File: rtl/core/c2ca_vec_if.sv
interface c2ca_vec_if #(
	parameter int COORD_BITS = c2ca_pkg::COORD_BITS_DEF
) ();
	import c2ca_pkg::*;

	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] vec_x;
	logic signed [COORD_BITS-1:0] vec_y;

	modport source (output valid, output vec_x, output vec_y, input ready);
	modport sink   (input valid, input vec_x, input vec_y, output ready);

endinterface

// File: rtl/core/c2ca_angle_if.sv
interface c2ca_angle_if ();
	import c2ca_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [ANGLE_BITS-1:0] angle_centideg;

	modport source (output valid, output angle_centideg, input ready);
	modport sink   (input valid, input angle_centideg, output ready);

endinterface

// File: rtl/core/c2ca_front.sv
module c2ca_front #(
	parameter int COORD_BITS      = c2ca_pkg::COORD_BITS_DEF,
	parameter int RATIO_FRAC_BITS = c2ca_pkg::RATIO_FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	c2ca_vec_if.sink                   vec,
	output logic                       dn_valid,
	input  logic                       dn_ready,
	output logic [COORD_BITS-1:0]      dn_rem,
	output logic [COORD_BITS-1:0]      dn_div,
	output logic [RATIO_FRAC_BITS:0]   dn_quo,
	output c2ca_pkg::octant_t          dn_oct
);
	import c2ca_pkg::*;

	logic                  valid_s1;
	logic                  en;
	logic [COORD_BITS-1:0] ax, ay, mag_lo, mag_hi;
	logic                  xn, yn, y_zero, x_small, top_bit;
	octant_t               oct;

	logic [COORD_BITS-1:0]    rem_s1, div_s1;
	logic [RATIO_FRAC_BITS:0] quo_s1;
	octant_t                  oct_s1;

	assign xn     = vec.vec_x[COORD_BITS-1];
	assign yn     = vec.vec_y[COORD_BITS-1];
	assign y_zero = (vec.vec_y == '0);
	// magnitude of the most negative code still fits unsigned
	assign ax     = xn ? (~vec.vec_x + 1'b1) : vec.vec_x;
	assign ay     = yn ? (~vec.vec_y + 1'b1) : vec.vec_y;

	// ties follow the signed comparisons exactly, rewritten on magnitudes
	always_comb begin
		oct.zero = 1'b0;
		if (!xn && !yn) begin
			if (ay > ax) begin
				oct.base = BASE_0;   oct.add = 1'b1; x_small = 1'b1;
			end else begin
				oct.base = BASE_90;  oct.add = 1'b0; x_small = 1'b0;
				oct.zero = (ax == '0);
			end
		end else if (!xn) begin
			if (ay <= ax) begin
				oct.base = BASE_90;  oct.add = 1'b1; x_small = 1'b0;
			end else begin
				oct.base = BASE_180; oct.add = 1'b0; x_small = 1'b1;
			end
		end else if (yn || y_zero) begin
			if (ay >= ax) begin
				oct.base = BASE_180; oct.add = 1'b1; x_small = 1'b1;
			end else begin
				oct.base = BASE_270; oct.add = 1'b0; x_small = 1'b0;
			end
		end else begin
			if (ay <= ax) begin
				oct.base = BASE_270; oct.add = 1'b1; x_small = 1'b0;
			end else begin
				oct.base = BASE_360; oct.add = 1'b0; x_small = 1'b1;
			end
		end
	end

	assign mag_lo  = x_small ? ax : ay;
	assign mag_hi  = x_small ? ay : ax;
	// mag_lo never exceeds mag_hi, so the integer quotient bit is just equality
	assign top_bit = (mag_lo >= mag_hi);

	assign en        = !valid_s1 || dn_ready;
	assign vec.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= vec.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && vec.valid) begin
			rem_s1 <= top_bit ? (mag_lo - mag_hi) : mag_lo;
			div_s1 <= mag_hi;
			quo_s1 <= {{RATIO_FRAC_BITS{1'b0}}, top_bit};
			oct_s1 <= oct;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_rem   = rem_s1;
	assign dn_div   = div_s1;
	assign dn_quo   = quo_s1;
	assign dn_oct   = oct_s1;

endmodule

// File: rtl/core/c2ca_div_cell.sv
module c2ca_div_cell #(
	parameter int COORD_BITS      = c2ca_pkg::COORD_BITS_DEF,
	parameter int RATIO_FRAC_BITS = c2ca_pkg::RATIO_FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     up_valid,
	output logic                     up_ready,
	input  logic [COORD_BITS-1:0]    up_rem,
	input  logic [COORD_BITS-1:0]    up_div,
	input  logic [RATIO_FRAC_BITS:0] up_quo,
	input  c2ca_pkg::octant_t        up_oct,
	output logic                     dn_valid,
	input  logic                     dn_ready,
	output logic [COORD_BITS-1:0]    dn_rem,
	output logic [COORD_BITS-1:0]    dn_div,
	output logic [RATIO_FRAC_BITS:0] dn_quo,
	output c2ca_pkg::octant_t        dn_oct
);
	import c2ca_pkg::*;

	logic                    valid_s1;
	logic                    en;
	logic [COORD_BITS:0]     rem2, diff;
	logic                    ge;

	logic [COORD_BITS-1:0]    rem_s1, div_s1;
	logic [RATIO_FRAC_BITS:0] quo_s1;
	octant_t                  oct_s1;

	// one restoring step: remainder stays below the divisor
	assign rem2 = {up_rem, 1'b0};
	assign ge   = (rem2 >= {1'b0, up_div});
	assign diff = rem2 - {1'b0, up_div};

	assign en       = !valid_s1 || dn_ready;
	assign up_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && up_valid) begin
			rem_s1 <= ge ? diff[COORD_BITS-1:0] : rem2[COORD_BITS-1:0];
			div_s1 <= up_div;
			quo_s1 <= {up_quo[RATIO_FRAC_BITS-1:0], ge};
			oct_s1 <= up_oct;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_rem   = rem_s1;
	assign dn_div   = div_s1;
	assign dn_quo   = quo_s1;
	assign dn_oct   = oct_s1;

endmodule

// File: rtl/core/c2ca_poly.sv
module c2ca_poly #(
	parameter int RATIO_FRAC_BITS = c2ca_pkg::RATIO_FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     up_valid,
	output logic                     up_ready,
	input  logic [RATIO_FRAC_BITS:0] up_ratio,
	input  c2ca_pkg::octant_t        up_oct,
	c2ca_angle_if.source             angle
);
	import c2ca_pkg::*;

	localparam int T_W  = RATIO_FRAC_BITS + 1;
	localparam int TA_W = COEF_A_W + T_W + 1;
	localparam int PT_W = P_W + T_W + 1;

	logic [5:1] v;
	logic [5:1] en;

	logic [T_W-1:0]  t_s1, t_s2;
	octant_t         oct_s1, oct_s2, oct_s3, oct_s4;
	logic signed [TA_W-1:0] ta_s1;
	logic signed [P_W-1:0]  p_s2;
	logic signed [PT_W-1:0] pt_s3;
	logic signed [Q_W-1:0]  q_s4;
	logic [ANGLE_BITS-1:0]  angle_s5;

	logic signed [Q_W-1:0]   q_n;
	logic signed [TOT_W-1:0] q_ext, total;
	logic signed [RND_W-1:0] rnd;
	logic [ANGLE_BITS-1:0]   angle_n;

	assign en[5] = !v[5] || angle.ready;
	assign en[4] = !v[4] || en[5];
	assign en[3] = !v[3] || en[4];
	assign en[2] = !v[2] || en[3];
	assign en[1] = !v[1] || en[2];
	assign up_ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else begin
			if (en[1]) v[1] <= up_valid;
			if (en[2]) v[2] <= v[1];
			if (en[3]) v[3] <= v[2];
			if (en[4]) v[4] <= v[3];
			if (en[5]) v[5] <= v[4];
		end
	end

	// floor shifts are part-selects of the signed products
	assign q_n   = {pt_s3[PT_W-1], pt_s3[PT_W-1:RATIO_FRAC_BITS]} + COEF_C;
	assign q_ext = {{(TOT_W-Q_W){q_s4[Q_W-1]}}, q_s4};
	assign total = oct_s4.add ? (base_bias(oct_s4.base) + q_ext)
	                          : (base_bias(oct_s4.base) - q_ext);
	assign rnd   = total[TOT_W-1:CFRAC];

	always_comb begin
		if (oct_s4.zero || rnd[RND_W-1]) begin
			angle_n = '0;
		end else if (rnd > RND_W'(ANGLE_MAX)) begin
			angle_n = ANGLE_BITS'(ANGLE_MAX);
		end else begin
			angle_n = rnd[ANGLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[1] && up_valid) begin
			ta_s1  <= TA_W'(COEF_A) * TA_W'($signed({1'b0, up_ratio}));
			t_s1   <= up_ratio;
			oct_s1 <= up_oct;
		end
		if (en[2] && v[1]) begin
			p_s2   <= $signed(ta_s1[TA_W-1:RATIO_FRAC_BITS]) + COEF_B;
			t_s2   <= t_s1;
			oct_s2 <= oct_s1;
		end
		if (en[3] && v[2]) begin
			pt_s3  <= PT_W'(p_s2) * PT_W'($signed({1'b0, t_s2}));
			oct_s3 <= oct_s2;
		end
		if (en[4] && v[3]) begin
			q_s4   <= q_n;
			oct_s4 <= oct_s3;
		end
		if (en[5] && v[4]) begin
			angle_s5 <= angle_n;
		end
	end

	assign angle.valid          = v[5];
	assign angle.angle_centideg = angle_s5;

endmodule

// File: rtl/core/cartesian_to_compass_angle_core.sv
// channel  role    beat payload
// -------  ------  ----------------------------------------------
// vec      sink    vec_x, vec_y (signed, COORD_BITS each)
// angle    source  angle_centideg (unsigned, 16 bits, 0..36000)
//
// One beat per cycle in and out unless the output stalls. Stages: one octant stage,
// one divider cell per fraction bit, then five polynomial and rounding stages.
// Reset clears only the stage valid flags.
// Every stage has its own ready, so a stalled output only holds up stages that are
// full; empty stages keep filling and beats keep being taken until the chain is full.
module cartesian_to_compass_angle_core #(
	parameter int COORD_BITS      = c2ca_pkg::COORD_BITS_DEF,
	parameter int RATIO_FRAC_BITS = c2ca_pkg::RATIO_FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	c2ca_vec_if.sink     vec,
	c2ca_angle_if.source angle
);
	import c2ca_pkg::*;

	localparam int NCELL = RATIO_FRAC_BITS;

	logic [NCELL:0]           valid_c;
	logic [NCELL:0]           ready_c;
	logic [COORD_BITS-1:0]    rem_c [NCELL+1];
	logic [COORD_BITS-1:0]    div_c [NCELL+1];
	logic [RATIO_FRAC_BITS:0] quo_c [NCELL+1];
	octant_t                  oct_c [NCELL+1];

	c2ca_front #(
		.COORD_BITS      (COORD_BITS),
		.RATIO_FRAC_BITS (RATIO_FRAC_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.vec      (vec),
		.dn_valid (valid_c[0]),
		.dn_ready (ready_c[0]),
		.dn_rem   (rem_c[0]),
		.dn_div   (div_c[0]),
		.dn_quo   (quo_c[0]),
		.dn_oct   (oct_c[0])
	);

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		c2ca_div_cell #(
			.COORD_BITS      (COORD_BITS),
			.RATIO_FRAC_BITS (RATIO_FRAC_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (valid_c[i]),
			.up_ready (ready_c[i]),
			.up_rem   (rem_c[i]),
			.up_div   (div_c[i]),
			.up_quo   (quo_c[i]),
			.up_oct   (oct_c[i]),
			.dn_valid (valid_c[i+1]),
			.dn_ready (ready_c[i+1]),
			.dn_rem   (rem_c[i+1]),
			.dn_div   (div_c[i+1]),
			.dn_quo   (quo_c[i+1]),
			.dn_oct   (oct_c[i+1])
		);
	end

	c2ca_poly #(
		.RATIO_FRAC_BITS (RATIO_FRAC_BITS)
	) u_poly (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (valid_c[NCELL]),
		.up_ready (ready_c[NCELL]),
		.up_ratio (quo_c[NCELL]),
		.up_oct   (oct_c[NCELL]),
		.angle    (angle)
	);

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import c2ca_pkg::*;

	localparam int     XY_BITS     = 16;
	localparam int     RATIO_BITS  = 16;
	localparam int     ANGLE_FRAC  = 20;
	localparam longint ATAN_A      = -64'sd1641298640;
	localparam longint ATAN_B      = 64'sd6360939112;
	localparam longint ATAN_C      = -64'sd524267;
	localparam longint FULL_TURN   = 36000;
	localparam int     PIPE_DEPTH  = RATIO_BITS + 6;
	localparam int     CYCLE_LIMIT = 300000;

	typedef struct {
		logic signed [XY_BITS-1:0] vx;
		logic signed [XY_BITS-1:0] vy;
		logic [ANGLE_BITS-1:0]     angle;
	} angle_expect_t;

	logic clk;
	logic arst_n;

	c2ca_vec_if #(.COORD_BITS(XY_BITS)) vec_bus ();
	c2ca_angle_if angle_bus ();

	cartesian_to_compass_angle_core #(
		.COORD_BITS      (XY_BITS),
		.RATIO_FRAC_BITS (RATIO_BITS)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.vec    (vec_bus),
		.angle  (angle_bus)
	);

	angle_expect_t pending_angles[$];
	angle_expect_t head_angle;
	int            fault_count = 0;
	bit            idling_on   = 1'b1;
	int            stall_left  = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// octant pick, ratio and quadratic, all at the block's fixed-point widths
	function automatic logic [ANGLE_BITS-1:0] compass_angle(input logic signed [XY_BITS-1:0] vx,
			input logic signed [XY_BITS-1:0] vy);
		longint x, y, ax, ay, num, den, t, p, q, acc;
		base_t  sel;
		bit     add_q;
		bit     x_small;
		x  = longint'(vx);
		y  = longint'(vy);
		ax = (x < 0) ? -x : x;
		ay = (y < 0) ? -y : y;
		if (x == 0 && y == 0)
			return '0;
		if (x >= 0) begin
			if (y >= 0) begin
				if (y > x) begin
					sel = BASE_0; add_q = 1'b1; x_small = 1'b1;
				end else begin
					sel = BASE_90; add_q = 1'b0; x_small = 1'b0;
				end
			end else if (-y <= x) begin
				sel = BASE_90; add_q = 1'b1; x_small = 1'b0;
			end else begin
				sel = BASE_180; add_q = 1'b0; x_small = 1'b1;
			end
		end else begin
			if (y <= 0) begin
				if (y <= x) begin
					sel = BASE_180; add_q = 1'b1; x_small = 1'b1;
				end else begin
					sel = BASE_270; add_q = 1'b0; x_small = 1'b0;
				end
			end else if (y <= -x) begin
				sel = BASE_270; add_q = 1'b1; x_small = 1'b0;
			end else begin
				sel = BASE_360; add_q = 1'b0; x_small = 1'b1;
			end
		end
		num = x_small ? ax : ay;
		den = x_small ? ay : ax;
		t = (num <<< RATIO_BITS) / den;
		p = ((ATAN_A * t) >>> RATIO_BITS) + ATAN_B;
		q = ((p * t) >>> RATIO_BITS) + ATAN_C;
		case (sel)
			BASE_0:   acc = 0;
			BASE_90:  acc = 9000;
			BASE_180: acc = 18000;
			BASE_270: acc = 27000;
			default:  acc = 36000;
		endcase
		acc = acc <<< ANGLE_FRAC;
		acc = add_q ? acc + q : acc - q;
		acc = (acc + (64'sd1 <<< (ANGLE_FRAC - 1))) >>> ANGLE_FRAC;
		if (acc < 0)
			acc = 0;
		if (acc > FULL_TURN)
			acc = FULL_TURN;
		return acc[ANGLE_BITS-1:0];
	endfunction

	// one beat in; an occasional gap of junk with valid low beforehand
	task automatic send_vector(input int vx, input int vy);
		int gap;
		angle_expect_t e;
		logic signed [XY_BITS-1:0] sx, sy;
		sx = XY_BITS'(vx);
		sy = XY_BITS'(vy);
		if (idling_on && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 14);
			@(negedge clk);
			vec_bus.valid <= 1'b0;
			vec_bus.vec_x <= XY_BITS'($urandom());
			vec_bus.vec_y <= XY_BITS'($urandom());
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		vec_bus.valid <= 1'b1;
		vec_bus.vec_x <= sx;
		vec_bus.vec_y <= sy;
		do
			@(posedge clk);
		while (!vec_bus.ready);
		e.vx    = sx;
		e.vy    = sy;
		e.angle = compass_angle(sx, sy);
		pending_angles.push_back(e);
	endtask

	task automatic test_zero_and_axes();
		send_vector(0, 0);
		send_vector(0, 1);
		send_vector(1, 0);
		send_vector(0, -1);
		send_vector(-1, 0);
		send_vector(0, 32767);
		send_vector(32767, 0);
		send_vector(0, -32768);
		send_vector(-32768, 0);
	endtask

	// equal magnitudes land on the tie side of each octant boundary
	task automatic test_diagonal_ties();
		send_vector(32767, 32767);
		send_vector(32767, -32767);
		send_vector(-32768, -32768);
		send_vector(-32767, 32767);
		send_vector(1, 1);
		send_vector(1, -1);
		send_vector(-1, -1);
		send_vector(-1, 1);
	endtask

	// tiny ratios: the negative offset rounds away, giving 0 near 0 and 36000 near 360
	task automatic test_near_axis_clamp();
		send_vector(1, 32767);
		send_vector(-1, 32767);
		send_vector(-32768, 32767);
		send_vector(32767, -32768);
		send_vector(-1, -32768);
		send_vector(1, -32768);
		send_vector(-32768, 1);
		send_vector(32767, -1);
	endtask

	task automatic send_random_vector();
		int x, y, d;
		int corners[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
		x = $signed(16'($urandom()));
		y = $signed(16'($urandom()));
		d = int'($urandom_range(0, 8)) - 4;
		case ($urandom_range(0, 9))
			4: begin
				x = int'($urandom_range(0, 16)) - 8;
				y = d;
			end
			5, 6: y = ($urandom_range(0, 1) ? x : -x) + d;
			7: y = d;
			8: x = d;
			9: begin
				x = corners[$urandom_range(0, 6)];
				y = corners[$urandom_range(0, 6)];
			end
			default: ;
		endcase
		send_vector(x, y);
	endtask

	task automatic test_random_vectors(input int count);
		repeat (count / 100) begin
			idling_on = ($urandom_range(0, 3) != 0);
			repeat (100) send_random_vector();
		end
	endtask

	task automatic test_back_to_back(input int count);
		idling_on = 1'b0;
		repeat (count) send_random_vector();
	endtask

	// result side: ready with random stall bursts
	initial begin
		angle_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				angle_bus.ready <= 1'b0;
				stall_left--;
			end else begin
				angle_bus.ready <= 1'b1;
				if (idling_on && $urandom_range(0, 9) == 0)
					stall_left = $urandom_range(1, 14);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && angle_bus.valid && angle_bus.ready) begin
			if (pending_angles.size() == 0) begin
				$display("%0t: unexpected angle beat: expected none, got %0d",
					$time, angle_bus.angle_centideg);
				fault_count++;
			end else begin
				head_angle = pending_angles.pop_front();
				if (angle_bus.angle_centideg !== head_angle.angle) begin
					$display("%0t: angle for (%0d,%0d): expected %0d, got %0d", $time,
						head_angle.vx, head_angle.vy, head_angle.angle,
						angle_bus.angle_centideg);
					fault_count++;
				end
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		vec_bus.valid = 1'b0;
		vec_bus.vec_x = '0;
		vec_bus.vec_y = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_zero_and_axes();
		test_diagonal_ties();
		test_near_axis_clamp();
		test_random_vectors(1100);
		test_back_to_back(200);

		@(negedge clk);
		vec_bus.valid <= 1'b0;
		while (pending_angles.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 10) @(posedge clk);

		if (fault_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: cartesian_to_compass_angle_core.f
rtl/core/c2ca_pkg.sv
rtl/core/c2ca_vec_if.sv
rtl/core/c2ca_angle_if.sv
rtl/core/c2ca_front.sv
rtl/core/c2ca_div_cell.sv
rtl/core/c2ca_poly.sv
rtl/core/cartesian_to_compass_angle_core.sv
tb/sv/tb_top.sv
